// ----- rtl/core/rdfd_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfd_pkg
// Shared widths, payload types and case codes of the robust depth
// finite difference pipeline.
// ----------------------------------------------------------------------------
package rdfd_pkg;

  localparam int IN_W          = 16;
  localparam int SAMPLE_BITS   = 16;
  localparam int FRACTION_BITS = 8;
  localparam int DERIV_W       = 25;
  localparam int CASE_W        = 3;

  localparam int USE_W  = (SAMPLE_BITS < IN_W) ? SAMPLE_BITS : IN_W;
  localparam int DIFF_W = USE_W + 1;
  localparam int SEC_W  = USE_W + 3;
  localparam int A_W    = USE_W + 1;
  localparam int DEN_W  = USE_W + 2;
  localparam int PROD_W = A_W + DIFF_W;
  localparam int NUM_W  = PROD_W + 1;
  localparam int DVD_W  = PROD_W + FRACTION_BITS;
  localparam int Q_W    = USE_W + FRACTION_BITS;

  localparam int DIV_STEP     = 4;
  localparam int DIV_STAGES   = (Q_W + DIV_STEP - 1) / DIV_STEP;
  localparam int QP_W         = DIV_STAGES * DIV_STEP;
  localparam int FRONT_STAGES = 3;
  localparam int PIPE_STAGES  = FRONT_STAGES + DIV_STAGES + 1;

  typedef enum logic [CASE_W-1:0] {
    CASE_OUTER = 3'd0,
    CASE_NONE  = 3'd1,
    CASE_LEFT  = 3'd2,
    CASE_RIGHT = 3'd3,
    CASE_BLEND = 3'd4
  } case_e;

  typedef struct packed {
    logic [IN_W-1:0] far_left;
    logic [IN_W-1:0] near_left;
    logic [IN_W-1:0] centre;
    logic [IN_W-1:0] near_right;
    logic [IN_W-1:0] far_right;
  } in_t;

  typedef struct packed {
    logic signed [DERIV_W-1:0] derivative;
    logic [CASE_W-1:0]         case_taken;
  } out_t;

  typedef struct packed {
    case_e                    kind;
    logic signed [DIFF_W-1:0] simple;
    logic                     neg;
    logic [DEN_W-1:0]         den;
    logic [DEN_W-1:0]         rem;
    logic [QP_W-1:0]          work;
  } div_t;

endpackage

// ----- rtl/core/rdfd_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfd_front
// Three pipeline stages: case selection and differences, weight products,
// numerator magnitude and divider setup.
// ----------------------------------------------------------------------------
module rdfd_front (
  input  logic                                      clk_i,
  input  logic                                      rst_ni,
  input  logic                                      valid_i,
  input  rdfd_pkg::in_t                             data_i,
  input  logic [rdfd_pkg::FRONT_STAGES-1:0]         en_i,
  output logic [rdfd_pkg::FRONT_STAGES-1:0]         valid_o,
  output rdfd_pkg::div_t                            data_o
);

  typedef struct packed {
    rdfd_pkg::case_e                    kind;
    logic signed [rdfd_pkg::DIFF_W-1:0] simple;
    logic signed [rdfd_pkg::DIFF_W-1:0] d_l;
    logic signed [rdfd_pkg::DIFF_W-1:0] d_r;
    logic signed [rdfd_pkg::DIFF_W-1:0] d_mean;
    logic [rdfd_pkg::A_W-1:0]           a;
    logic [rdfd_pkg::A_W-1:0]           b;
  } st1_t;

  typedef struct packed {
    rdfd_pkg::case_e                    kind;
    logic signed [rdfd_pkg::DIFF_W-1:0] simple;
    logic signed [rdfd_pkg::PROD_W-1:0] prod_l;
    logic signed [rdfd_pkg::PROD_W-1:0] prod_r;
    logic signed [rdfd_pkg::DIFF_W-1:0] d_mean;
    logic [rdfd_pkg::DEN_W-1:0]         den;
  } st2_t;

  function automatic logic signed [rdfd_pkg::DIFF_W-1:0] diff_f(
    input logic [rdfd_pkg::USE_W-1:0] x,
    input logic [rdfd_pkg::USE_W-1:0] y
  );
    return signed'({1'b0, x}) - signed'({1'b0, y});
  endfunction

  function automatic logic [rdfd_pkg::A_W-1:0] curv_f(
    input logic [rdfd_pkg::USE_W-1:0] x,
    input logic [rdfd_pkg::USE_W-1:0] mid,
    input logic [rdfd_pkg::USE_W-1:0] y
  );
    logic signed [rdfd_pkg::SEC_W-1:0] sec;
    sec = signed'(rdfd_pkg::SEC_W'(x)) + signed'(rdfd_pkg::SEC_W'(y))
        - signed'(rdfd_pkg::SEC_W'({mid, 1'b0}));
    if (sec[rdfd_pkg::SEC_W-1]) begin
      sec = -sec;
    end
    return sec[rdfd_pkg::A_W-1:0];
  endfunction

  logic [rdfd_pkg::USE_W-1:0] s0, s1, s2, s3, s4;
  logic                       z0, z1, z3, z4;
  st1_t                       st1_d, st1_q;
  st2_t                       st2_d, st2_q;
  rdfd_pkg::div_t             st3_d, st3_q;
  logic [rdfd_pkg::FRONT_STAGES-1:0] valid_q;

  logic signed [rdfd_pkg::NUM_W-1:0]  num;
  logic [rdfd_pkg::DEN_W-1:0]         den_use;
  logic [rdfd_pkg::PROD_W-1:0]        mag;
  logic [rdfd_pkg::DVD_W-1:0]         dividend;

  // stage 1: classify and take differences
  always_comb begin
    s0 = data_i.far_left[rdfd_pkg::USE_W-1:0];
    s1 = data_i.near_left[rdfd_pkg::USE_W-1:0];
    s2 = data_i.centre[rdfd_pkg::USE_W-1:0];
    s3 = data_i.near_right[rdfd_pkg::USE_W-1:0];
    s4 = data_i.far_right[rdfd_pkg::USE_W-1:0];
    z0 = (s0 == '0);
    z1 = (s1 == '0);
    z3 = (s3 == '0);
    z4 = (s4 == '0);

    st1_d.d_l    = diff_f(s2, s0);
    st1_d.d_r    = diff_f(s4, s2);
    st1_d.d_mean = diff_f(s4, s0);
    st1_d.a      = curv_f(s2, s1, s0);
    st1_d.b      = curv_f(s4, s3, s2);

    if (z0 && z4 && !z1 && !z3) begin
      st1_d.kind   = rdfd_pkg::CASE_OUTER;
      st1_d.simple = diff_f(s3, s1);
    end else if ((z0 || z1) && (z3 || z4)) begin
      st1_d.kind   = rdfd_pkg::CASE_NONE;
      st1_d.simple = '0;
    end else if (z0 || z1) begin
      st1_d.kind   = rdfd_pkg::CASE_LEFT;
      st1_d.simple = st1_d.d_r;
    end else if (z3 || z4) begin
      st1_d.kind   = rdfd_pkg::CASE_RIGHT;
      st1_d.simple = st1_d.d_l;
    end else begin
      st1_d.kind   = rdfd_pkg::CASE_BLEND;
      st1_d.simple = '0;
    end
  end

  // stage 2: weighted products and weight sum
  always_comb begin
    st2_d.kind   = st1_q.kind;
    st2_d.simple = st1_q.simple;
    st2_d.d_mean = st1_q.d_mean;
    st2_d.prod_l = signed'(rdfd_pkg::PROD_W'(st1_q.b)) * rdfd_pkg::PROD_W'(st1_q.d_l);
    st2_d.prod_r = signed'(rdfd_pkg::PROD_W'(st1_q.a)) * rdfd_pkg::PROD_W'(st1_q.d_r);
    st2_d.den    = rdfd_pkg::DEN_W'(st1_q.a) + rdfd_pkg::DEN_W'(st1_q.b);
  end

  // stage 3: numerator, sign split and divider setup
  always_comb begin
    if (st2_q.den == '0) begin
      num     = rdfd_pkg::NUM_W'(st2_q.d_mean);
      den_use = rdfd_pkg::DEN_W'(2);
    end else begin
      num     = rdfd_pkg::NUM_W'(st2_q.prod_l) + rdfd_pkg::NUM_W'(st2_q.prod_r);
      den_use = st2_q.den;
    end
    if (num[rdfd_pkg::NUM_W-1]) begin
      mag = rdfd_pkg::PROD_W'(-num);
    end else begin
      mag = rdfd_pkg::PROD_W'(num);
    end
    dividend = rdfd_pkg::DVD_W'(mag) << rdfd_pkg::FRACTION_BITS;

    st3_d.kind   = st2_q.kind;
    st3_d.simple = st2_q.simple;
    st3_d.neg    = num[rdfd_pkg::NUM_W-1];
    st3_d.den    = den_use;
    st3_d.rem    = rdfd_pkg::DEN_W'(dividend[rdfd_pkg::DVD_W-1:rdfd_pkg::QP_W]);
    st3_d.work   = dividend[rdfd_pkg::QP_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en_i[0]) begin
        valid_q[0] <= valid_i;
      end
      if (en_i[1]) begin
        valid_q[1] <= valid_q[0];
      end
      if (en_i[2]) begin
        valid_q[2] <= valid_q[1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      st1_q <= st1_d;
    end
    if (en_i[1]) begin
      st2_q <= st2_d;
    end
    if (en_i[2]) begin
      st3_q <= st3_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = st3_q;

endmodule

// ----- rtl/core/rdfd_div_stage.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rdfd_div_stage
// One registered stage of the restoring divider, a few quotient bits per
// stage.
// ----------------------------------------------------------------------------
module rdfd_div_stage (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           valid_i,
  input  rdfd_pkg::div_t data_i,
  input  logic           en_i,
  output logic           valid_o,
  output rdfd_pkg::div_t data_o
);

  logic [rdfd_pkg::DEN_W:0]   trial;
  logic [rdfd_pkg::DEN_W-1:0] rem;
  logic [rdfd_pkg::QP_W-1:0]  work;
  logic                       qbit;
  rdfd_pkg::div_t             data_d, data_q;
  logic                       valid_q;

  always_comb begin
    rem  = data_i.rem;
    work = data_i.work;
    trial = '0;
    qbit  = 1'b0;
    for (int i = 0; i < rdfd_pkg::DIV_STEP; i++) begin
      trial = {rem, work[rdfd_pkg::QP_W-1]};
      if (trial >= {1'b0, data_i.den}) begin
        trial = trial - {1'b0, data_i.den};
        qbit  = 1'b1;
      end else begin
        qbit  = 1'b0;
      end
      rem  = trial[rdfd_pkg::DEN_W-1:0];
      work = {work[rdfd_pkg::QP_W-2:0], qbit};
    end
    data_d      = data_i;
    data_d.rem  = rem;
    data_d.work = work;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

// ----- rtl/core/robust_depth_finite_difference_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// robust_depth_finite_difference_top
// Five-sample depth derivative with missing-depth handling and
// curvature-weighted blending of the two one-sided differences.
// ----------------------------------------------------------------------------
// usage:
//   in channel : in_valid_i / in_ready_o, five depth samples per transaction
//   out channel: out_valid_o / out_ready_i, derivative and case code
//   stages     : 3 front stages + 6 divider stages + 1 output register
//   throughput : one transaction per cycle when not stalled; the divider retires 4
//                quotient bits per stage so every stage can take a new item each cycle
//   reset      : all valid bits clear, no result is pending, in_ready_o high
//   stall      : a held result keeps its register; earlier stages keep
//                moving into empty slots, so in_ready_o drops only when the
//                whole pipeline is full and the receiver is not ready
// ----------------------------------------------------------------------------
module robust_depth_finite_difference_top (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  rdfd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output rdfd_pkg::out_t out_data_o
);

  localparam int NS = rdfd_pkg::PIPE_STAGES;
  localparam int NF = rdfd_pkg::FRONT_STAGES;
  localparam int ND = rdfd_pkg::DIV_STAGES;

  logic [NS-1:0]  vld;
  logic [NS-1:0]  en;
  rdfd_pkg::div_t div_s [ND+1];
  logic [ND:0]    div_v;
  logic [NF-1:0]  front_v;

  logic                                out_valid_q;
  rdfd_pkg::out_t                      out_d, out_q;
  logic [rdfd_pkg::DERIV_W-1:0]        qt;
  logic signed [rdfd_pkg::DIFF_W+rdfd_pkg::FRACTION_BITS-1:0] sc;

  // stall chain: a stage moves when it is empty or the next one moves
  always_comb begin
    en[NS-1] = !vld[NS-1] || out_ready_i;
    for (int k = NS - 2; k >= 0; k--) begin
      en[k] = !vld[k] || en[k+1];
    end
  end

  assign in_ready_o = en[0];

  rdfd_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .data_i  (in_data_i),
    .en_i    (en[NF-1:0]),
    .valid_o (front_v),
    .data_o  (div_s[0])
  );

  assign div_v[0]      = front_v[NF-1];
  assign vld[NF-1:0]   = front_v;

  for (genvar g = 0; g < ND; g++) begin : g_div
    rdfd_div_stage u_div (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_v[g]),
      .data_i  (div_s[g]),
      .en_i    (en[NF+g]),
      .valid_o (div_v[g+1]),
      .data_o  (div_s[g+1])
    );
    assign vld[NF+g] = div_v[g+1];
  end

  // output stage: sign and case select
  always_comb begin
    qt = rdfd_pkg::DERIV_W'(div_s[ND].work);
    sc = signed'((rdfd_pkg::DIFF_W+rdfd_pkg::FRACTION_BITS)'(div_s[ND].simple))
         <<< rdfd_pkg::FRACTION_BITS;
    out_d.case_taken = div_s[ND].kind;
    case (div_s[ND].kind)
      rdfd_pkg::CASE_BLEND: begin
        out_d.derivative = div_s[ND].neg ? signed'(-qt) : signed'(qt);
      end
      rdfd_pkg::CASE_NONE: begin
        out_d.derivative = '0;
      end
      default: begin
        out_d.derivative = rdfd_pkg::DERIV_W'(sc);
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en[NS-1]) begin
      out_valid_q <= div_v[ND];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[NS-1]) begin
      out_q <= out_d;
    end
  end

  assign vld[NS-1]   = out_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef NO_ASSERTIONS
  // input side stalls only under output backpressure
  a_ready_only_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_valid_o && !out_ready_i))
    else $error("input stalled without output backpressure");

  // no invalid side pair gives a nonzero derivative
  a_none_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.case_taken == rdfd_pkg::CASE_NONE))
      |-> (out_data_o.derivative == '0))
    else $error("both sides invalid but derivative nonzero");

  // a full pipeline that is drained by the receiver frees the input
  a_drain_frees_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("input not ready while output is drained");
`endif

endmodule
